>>> sv/nerf_pkg.sv
// ----------------------------------------------------------------------------
// nerf_pkg
// Shared constants and types for the nearest edge radius finder.
// ----------------------------------------------------------------------------
package nerf_pkg;

  localparam int unsigned CfgW        = 13;
  localparam int unsigned SqW         = 23;
  localparam int unsigned RootW       = 12;
  localparam int unsigned RootSteps   = 12;
  localparam int unsigned MaxWidthDef  = 4096;
  localparam int unsigned MaxHeightDef = 4096;

  localparam logic [SqW-1:0]  SqMax       = {SqW{1'b1}};
  localparam logic [CfgW-1:0] WidthReset  = 13'd640;
  localparam logic [CfgW-1:0] HeightReset = 13'd480;

  localparam logic CfgIdxWidth  = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;

  typedef struct packed {
    logic load_x;
    logic load_y;
  } sq_ctrl_t;

endpackage

>>> sv/nearest_edge_radius_finder_top.sv
// ----------------------------------------------------------------------------
// nearest_edge_radius_finder_top
// Nearest edge to the frame center, reported as an integer radius per frame.
// ----------------------------------------------------------------------------
// A pixel that is not an edge needs only its transfer, so plain raster data
// streams at one pixel per clock outside the frame end. An edge pixel takes the
// transfer, then three steps through the single shared squarer (dx squared,
// dy squared, sum and minimum). The last pixel of a frame adds a start step
// and the bit-serial square root before the next pixel transfer; the result
// then sits in an output register until taken, and while an earlier result
// still waits there the frame end holds until it is taken.
module nearest_edge_radius_finder_top #(
  parameter int unsigned MAX_WIDTH  = nerf_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = nerf_pkg::MaxHeightDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_addr_i,
  input  logic [nerf_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       pixel_on_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [nerf_pkg::RootW-1:0] min_radius_o,
  output logic                       edge_found_o
);

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned DxW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH / 2 + 1) : 1;
  localparam int unsigned DyW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT / 2 + 1) : 1;
  localparam int unsigned OpW  = (DxW > DyW) ? DxW : DyW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ACC,
    ST_START,
    ST_ROOT
  } state_e;

  state_e                     state_q;
  logic [nerf_pkg::CfgW-1:0]  cfg_width_q;
  logic [nerf_pkg::CfgW-1:0]  cfg_height_q;
  logic [ColW-1:0]            col_q;
  logic [RowW-1:0]            row_q;
  logic                       prev_q;
  logic                       frame_end_q;
  logic [nerf_pkg::SqW-1:0]   min_q;
  logic [OpW-1:0]             dx_q;
  logic [OpW-1:0]             dy_q;
  logic                       out_valid_q;
  logic [nerf_pkg::RootW-1:0] min_radius_q;
  logic                       edge_found_q;

  logic [31:0] wcfg, hcfg, w32, h32, cx32, cy32, col32, row32;
  logic [31:0] dx32, dy32, limit32, root32;
  logic        right_hit, left_hit, edge_hit, col_last, row_last, accept, found;
  logic        result_load;

  nerf_pkg::sq_ctrl_t         sq_ctrl;
  logic [nerf_pkg::SqW-1:0]   sq;
  logic                       root_busy;
  logic [nerf_pkg::RootW-1:0] root;

  always_comb begin
    wcfg = 32'(cfg_width_q);
    hcfg = 32'(cfg_height_q);
    if (wcfg < 32'd2) begin
      w32 = 32'd2;
    end else if (wcfg > 32'(MAX_WIDTH)) begin
      w32 = 32'(MAX_WIDTH);
    end else begin
      w32 = wcfg;
    end
    if (hcfg < 32'd1) begin
      h32 = 32'd1;
    end else if (hcfg > 32'(MAX_HEIGHT)) begin
      h32 = 32'(MAX_HEIGHT);
    end else begin
      h32 = hcfg;
    end
  end

  assign cx32    = w32 >> 1;
  assign cy32    = h32 >> 1;
  assign col32   = 32'(col_q);
  assign row32   = 32'(row_q);
  assign limit32 = cx32 + 32'd1;

  assign right_hit = (col32 >= cx32 + 32'd1) && (col32 <= w32 - 32'd1) && prev_q && !pixel_on_i;
  assign left_hit  = (col32 >= 32'd1) && (col32 <= cx32) && pixel_on_i && !prev_q;
  assign edge_hit  = right_hit || left_hit;
  assign dx32      = right_hit ? (col32 - 32'd1 - cx32) : (cx32 - col32);
  assign dy32      = (row32 < cy32) ? (cy32 - row32) : (row32 - cy32);
  assign col_last  = col32 >= w32 - 32'd1;
  assign row_last  = row32 >= h32 - 32'd1;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign sq_ctrl.load_x = (state_q == ST_MUL_X);
  assign sq_ctrl.load_y = (state_q == ST_MUL_Y);

  nerf_sq_unit #(
    .OpW (OpW)
  ) u_sq (
    .clk_i  (clk_i),
    .ctrl_i (sq_ctrl),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .sq_o   (sq)
  );

  nerf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_START),
    .value_i (min_q),
    .busy_o  (root_busy),
    .root_o  (root)
  );

  assign root32 = 32'(root);
  assign found  = root32 < limit32;

  assign result_load = (state_q == ST_ROOT) && !root_busy && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cfg_width_q  <= nerf_pkg::WidthReset;
      cfg_height_q <= nerf_pkg::HeightReset;
      col_q        <= '0;
      row_q        <= '0;
      prev_q       <= 1'b0;
      frame_end_q  <= 1'b0;
      min_q        <= nerf_pkg::SqMax;
      dx_q         <= '0;
      dy_q         <= '0;
      out_valid_q  <= 1'b0;
      min_radius_q <= '0;
      edge_found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          nerf_pkg::CfgIdxWidth:  cfg_width_q  <= cfg_wdata_i;
          nerf_pkg::CfgIdxHeight: cfg_height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (result_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            dx_q        <= dx32[OpW-1:0];
            dy_q        <= dy32[OpW-1:0];
            frame_end_q <= col_last && row_last;
            if (col_last) begin
              col_q  <= '0;
              prev_q <= 1'b0;
              if (row_last) begin
                row_q <= '0;
              end else begin
                row_q <= RowW'(row32 + 32'd1);
              end
            end else begin
              col_q  <= ColW'(col32 + 32'd1);
              prev_q <= pixel_on_i;
            end
            if (edge_hit) begin
              state_q <= ST_MUL_X;
            end else if (col_last && row_last) begin
              state_q <= ST_START;
            end
          end
        end
        ST_MUL_X: state_q <= ST_MUL_Y;
        ST_MUL_Y: state_q <= ST_ACC;
        ST_ACC: begin
          if (sq < min_q) begin
            min_q <= sq;
          end
          state_q <= frame_end_q ? ST_START : ST_IDLE;
        end
        ST_START: begin
          min_q   <= nerf_pkg::SqMax;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          if (result_load) begin
            edge_found_q <= found;
            min_radius_q <= found ? root : limit32[nerf_pkg::RootW-1:0];
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign min_radius_o = min_radius_q;
  assign edge_found_o = edge_found_q;

  a_ready_not_rooting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !root_busy)
    else $error("pixel transfer possible while square root runs");

  a_root_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(root_busy) |-> $past(state_q == ST_START))
    else $error("square root started outside frame end");

  a_min_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START) |=> (min_q == nerf_pkg::SqMax))
    else $error("minimum not cleared at frame end");

endmodule

>>> sv/nerf_sq_unit.sv
// ----------------------------------------------------------------------------
// nerf_sq_unit
// Shared squarer: squares dx, then dy, and presents the saturated sum.
// ----------------------------------------------------------------------------
module nerf_sq_unit #(
  parameter int unsigned OpW = 12
) (
  input  logic                       clk_i,
  input  nerf_pkg::sq_ctrl_t         ctrl_i,
  input  logic [OpW-1:0]             dx_i,
  input  logic [OpW-1:0]             dy_i,
  output logic [nerf_pkg::SqW-1:0]   sq_o
);

  logic [OpW-1:0]   operand;
  logic [2*OpW-1:0] product;
  logic [2*OpW-1:0] prod_q;
  logic [2*OpW-1:0] acc_q;
  logic [2*OpW:0]   sum;
  logic [63:0]      sum64;

  assign operand = ctrl_i.load_y ? dy_i : dx_i;
  assign product = operand * operand;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_x || ctrl_i.load_y) begin
      prod_q <= product;
    end
    if (ctrl_i.load_y) begin
      acc_q <= prod_q;
    end
  end

  assign sum   = {1'b0, acc_q} + {1'b0, prod_q};
  assign sum64 = 64'(sum);
  assign sq_o  = (sum64 > 64'(nerf_pkg::SqMax)) ? nerf_pkg::SqMax : sum64[nerf_pkg::SqW-1:0];

endmodule

>>> sv/nerf_isqrt.sv
// ----------------------------------------------------------------------------
// nerf_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module nerf_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [nerf_pkg::SqW-1:0]   value_i,
  output logic                       busy_o,
  output logic [nerf_pkg::RootW-1:0] root_o
);

  localparam int unsigned StepW = $clog2(nerf_pkg::RootSteps);

  logic                      busy_q;
  logic [StepW-1:0]          step_q;
  logic [nerf_pkg::SqW-1:0]  rem_q;
  logic [nerf_pkg::SqW:0]    res_q;
  logic [nerf_pkg::SqW:0]    bit_val;
  logic [nerf_pkg::SqW:0]    trial;
  logic                      take;

  assign bit_val = (nerf_pkg::SqW+1)'(1) << {step_q, 1'b0};
  assign trial   = res_q + bit_val;
  assign take    = {1'b0, rem_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      res_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= StepW'(nerf_pkg::RootSteps - 1);
      rem_q  <= value_i;
      res_q  <= '0;
    end else if (busy_q) begin
      if (take) begin
        rem_q <= rem_q - trial[nerf_pkg::SqW-1:0];
        res_q <= (res_q >> 1) + bit_val;
      end else begin
        res_q <= res_q >> 1;
      end
      if (step_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = res_q[nerf_pkg::RootW-1:0];

endmodule
